@@ rtl/imm_pkg.sv @@
// ----------------------------------------------------------------------------
// imm_pkg
// Shared constants, codes and controller/datapath interface types for the
// integer square matrix multiplier.
// ----------------------------------------------------------------------------
package imm_pkg;

    localparam int MAX_SIZE   = 16;
    localparam int IDX_W      = $clog2(MAX_SIZE);
    localparam int ADDR_W     = 2 * IDX_W;
    localparam int CELLS      = MAX_SIZE * MAX_SIZE;
    localparam int SIZE_W     = 5;
    localparam int ELEM_W     = 32;
    localparam int ACC_W      = 64;
    localparam int ACTION_W   = 2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);
    localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(MAX_SIZE);

    localparam logic [ACTION_W-1:0] ACT_LOAD_A = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LOAD_B = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic             wr_a;
        logic             wr_b;
        logic             capture;
        logic             issue;
        logic [IDX_W-1:0] k;
        logic             emit;
    } imm_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic             query_bad;
        logic [IDX_W-1:0] n_last;
        logic             pipe_busy;
        logic             out_free;
    } imm_stat_t;

endpackage

@@ rtl/imm_ctrl.sv @@
// ----------------------------------------------------------------------------
// imm_ctrl
// Controller: decodes input words, steps the shared index of a query and
// sequences drain and result hand-off.
// ----------------------------------------------------------------------------
module imm_ctrl import imm_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [ACTION_W-1:0] s_action,
    input  imm_stat_t           stat,
    output imm_cmd_t            cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic             take;

    assign s_tready = (state_reg == ST_IDLE);
    assign take     = s_tvalid && s_tready;

    always_comb begin
        state_next  = state_reg;
        k_next      = k_reg;
        cmd         = '0;
        cmd.k       = k_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (take) begin
                    cmd.wr_a    = (s_action == ACT_LOAD_A);
                    cmd.wr_b    = (s_action == ACT_LOAD_B);
                    if (s_action == ACT_QUERY) begin
                        cmd.capture = 1'b1;
                        k_next      = '0;
                        state_next  = stat.query_bad ? ST_EMIT : ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                cmd.issue = 1'b1;
                if (k_reg == stat.n_last) begin
                    state_next = ST_DRAIN;
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (!stat.pipe_busy) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // hold until the output register is free
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

endmodule

@@ rtl/imm_dp.sv @@
// ----------------------------------------------------------------------------
// imm_dp
// Datapath: element stores for A and B, registered reads, one 32x32 signed
// multiplier, 64-bit accumulator, size register and output register.
// ----------------------------------------------------------------------------
module imm_dp import imm_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [SIZE_W-1:0]  cfg_wr_data,
    input  logic [IDX_W-1:0]   s_row,
    input  logic [IDX_W-1:0]   s_col,
    input  logic [ELEM_W-1:0]  s_elem,
    input  imm_cmd_t           cmd,
    output imm_stat_t          stat,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [ACC_W-1:0]   m_value,
    output logic [IDX_W-1:0]   m_row,
    output logic [IDX_W-1:0]   m_col,
    output logic               m_oor
);

    logic [ELEM_W-1:0] mem_a [0:CELLS-1];
    logic [ELEM_W-1:0] mem_b [0:CELLS-1];

    logic [SIZE_W-1:0] size_reg;
    logic [SIZE_W-1:0] n_active;
    logic [SIZE_W-1:0] n_minus1;

    logic [IDX_W-1:0]  q_row_reg;
    logic [IDX_W-1:0]  q_col_reg;
    logic              q_bad_reg;

    logic [ELEM_W-1:0] a_rd_reg;
    logic [ELEM_W-1:0] b_rd_reg;
    logic              rd_vld_reg;
    logic signed [ACC_W-1:0] prod_full;
    logic [ACC_W-1:0]  prod_reg;
    logic              prod_vld_reg;
    logic [ACC_W-1:0]  acc_reg;

    logic              m_valid_reg;
    logic [ACC_W-1:0]  m_value_reg;
    logic [IDX_W-1:0]  m_row_reg;
    logic [IDX_W-1:0]  m_col_reg;
    logic              m_oor_reg;

    assign n_active = (size_reg > SIZE_MAX) ? SIZE_MAX : size_reg;
    assign n_minus1 = n_active - 1'b1;

    assign stat.query_bad = ({1'b0, s_row} >= n_active) || ({1'b0, s_col} >= n_active);
    assign stat.n_last    = n_minus1[IDX_W-1:0];
    assign stat.pipe_busy = rd_vld_reg || prod_vld_reg;
    assign stat.out_free  = !m_valid_reg || m_ready;

    // sign-extend both operands to the full 64-bit product
    assign prod_full = $signed(a_rd_reg) * $signed(b_rd_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= SIZE_RESET;
        end else if (cfg_wr_en) begin
            size_reg <= cfg_wr_data;
        end
    end

    // element stores
    always_ff @(posedge aclk) begin
        if (cmd.wr_a) begin
            mem_a[{s_row, s_col}] <= s_elem;
        end
        if (cmd.wr_b) begin
            mem_b[{s_row, s_col}] <= s_elem;
        end
        if (cmd.issue) begin
            a_rd_reg <= mem_a[{q_row_reg, cmd.k}];
            b_rd_reg <= mem_b[{cmd.k, q_col_reg}];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            q_row_reg <= s_row;
            q_col_reg <= s_col;
            q_bad_reg <= stat.query_bad;
        end
        if (rd_vld_reg) begin
            prod_reg <= prod_full;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg   <= cmd.issue;
            prod_vld_reg <= rd_vld_reg;
        end
    end

    // accumulate, wrapping modulo 2^64
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            acc_reg <= '0;
        end else if (prod_vld_reg) begin
            acc_reg <= acc_reg + prod_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_value_reg <= q_bad_reg ? '0 : acc_reg;
            m_row_reg   <= q_row_reg;
            m_col_reg   <= q_col_reg;
            m_oor_reg   <= q_bad_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_value = m_value_reg;
    assign m_row   = m_row_reg;
    assign m_col   = m_col_reg;
    assign m_oor   = m_oor_reg;

endmodule

@@ rtl/integer_matrix_multiply_top.sv @@
// ----------------------------------------------------------------------------
// integer_matrix_multiply_top
// Square integer matrix multiplier: loads elements of A and B, answers
// queries for single entries of C = A*B with a 64-bit wrapping sum.
//
//   channel  direction  payload
//   s_*      in         tuser: action; tdata: row, col, element
//   m_*      out        tuser: out_of_range; tdata: value, row, col
//   cfg_*    in         size in use (5 bits)
//
// A load writes its element store when accepted. An in-range query runs the
// accept, one read of each element store per shared index below the size in
// use through a single multiplier, a drain of the read, multiply and
// accumulate stages and the load of the output register; an out-of-range
// query skips the reads and drain. Reset is synchronous and active low; the
// element stores are not cleared. While a result waits on m_tready, loads
// keep flowing; a finished query holds until the output register frees.
// ----------------------------------------------------------------------------
module integer_matrix_multiply_top import imm_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [4:0]   cfg_wr_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [39:0]  s_tdata,   // [3:0] row_index, [7:4] col_index, [39:8] element_value
    input  logic [1:0]   s_tuser,   // [1:0] action
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata,   // [63:0] product_value, [67:64] product_row,
                                    // [71:68] product_col
    output logic [0:0]   m_tuser    // [0] out_of_range
);

    imm_cmd_t          cmd;
    imm_stat_t         stat;
    logic [ACC_W-1:0]  m_value;
    logic [IDX_W-1:0]  m_row;
    logic [IDX_W-1:0]  m_col;
    logic              m_oor;

    imm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_action (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    imm_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_row       (s_tdata[3:0]),
        .s_col       (s_tdata[7:4]),
        .s_elem      (s_tdata[39:8]),
        .cmd         (cmd),
        .stat        (stat),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .m_value     (m_value),
        .m_row       (m_row),
        .m_col       (m_col),
        .m_oor       (m_oor)
    );

    assign m_tdata = {m_col, m_row, m_value};
    assign m_tuser = m_oor;

endmodule
